// ----- design/serial_module_link_bridge_top_assert.svh -----
// Assertion macros shared by the link bridge RTL.
`ifndef SERIAL_MODULE_LINK_BRIDGE_TOP_ASSERT_SVH
`define SERIAL_MODULE_LINK_BRIDGE_TOP_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define SMLB_ASSERT_HOLDS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define SMLB_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define SMLB_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/smlb_pkg.sv -----
// Package for the link bridge: phase codes, result word type and string tables.
package smlb_pkg;

    localparam int SMLB_FIFO_DEPTH = 32;

    // Sequencer phases; the connected phase bridges data in both directions.
    typedef enum logic [3:0] {
        PH_RST_START   = 4'd0,
        PH_RST_SEND    = 4'd1,
        PH_READY_START = 4'd2,
        PH_READY_WAIT  = 4'd3,
        PH_INQ_START   = 4'd4,
        PH_INQ_SEND    = 4'd5,
        PH_SCAN_START  = 4'd6,
        PH_SCAN_WAIT   = 4'd7,
        PH_CONN_START  = 4'd8,
        PH_CONN_WAIT   = 4'd9,
        PH_LINK_UP     = 4'd10,
        PH_CONNECTED   = 4'd11,
        PH_VERIFY      = 4'd12
    } t_phase;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;

    localparam logic       CMD_RESET = 1'b0;
    localparam logic       CMD_INQ   = 1'b1;

    localparam logic [1:0] NTC_READY = 2'd0;
    localparam logic [1:0] NTC_INQ   = 2'd1;
    localparam logic [1:0] NTC_CONN  = 2'd2;

    localparam logic [2:0] ERR_LEN   = 3'd5;

    // One result word as it leaves the block.
    typedef struct packed {
        logic       tm_valid;
        logic [7:0] tm_byte;
        logic       tl_valid;
        logic [7:0] tl_byte;
        logic [3:0] phase;
    } t_result;

    // Length of the selected command string.
    function automatic logic [3:0] cmd_len(input logic sel);
        return (sel == CMD_INQ) ? 4'd10 : 4'd13;
    endfunction

    // Character of the selected command; zero beyond its end.
    function automatic logic [7:0] cmd_char(input logic sel, input logic [3:0] pos);
        logic [7:0] c;
        c = 8'h00;
        if (sel == CMD_INQ) begin
            unique case (pos)
                4'd0:    c = CHAR_CR;
                4'd1:    c = CHAR_LF;
                4'd2:    c = "+";
                4'd3:    c = "I";
                4'd4:    c = "N";
                4'd5:    c = "Q";
                4'd6:    c = "=";
                4'd7:    c = "1";
                4'd8:    c = CHAR_CR;
                4'd9:    c = CHAR_LF;
                default: c = 8'h00;
            endcase
        end else begin
            unique case (pos)
                4'd0:    c = CHAR_CR;
                4'd1:    c = CHAR_LF;
                4'd2:    c = "+";
                4'd3:    c = "S";
                4'd4:    c = "T";
                4'd5:    c = "W";
                4'd6:    c = "M";
                4'd7:    c = "O";
                4'd8:    c = "D";
                4'd9:    c = "=";
                4'd10:   c = "0";
                4'd11:   c = CHAR_CR;
                4'd12:   c = CHAR_LF;
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    // Length of the selected notice string.
    function automatic logic [3:0] ntc_len(input logic [1:0] sel);
        return (sel == NTC_READY) ? 4'd11 : 4'd12;
    endfunction

    // Character of the selected notice; the unused selector matches as connected.
    function automatic logic [7:0] ntc_char(input logic [1:0] sel, input logic [3:0] pos);
        logic [7:0] c;
        c = 8'h00;
        if (sel == NTC_READY) begin
            unique case (pos)
                4'd0:    c = CHAR_LF;
                4'd1:    c = "+";
                4'd2:    c = "B";
                4'd3:    c = "T";
                4'd4:    c = "S";
                4'd5:    c = "T";
                4'd6:    c = "A";
                4'd7:    c = "T";
                4'd8:    c = "E";
                4'd9:    c = ":";
                4'd10:   c = "1";
                default: c = 8'h00;
            endcase
        end else begin
            unique case (pos)
                4'd0:    c = "+";
                4'd1:    c = "B";
                4'd2:    c = "T";
                4'd3:    c = "S";
                4'd4:    c = "T";
                4'd5:    c = "A";
                4'd6:    c = "T";
                4'd7:    c = "E";
                4'd8:    c = ":";
                4'd9:    c = (sel == NTC_INQ) ? "2" : "4";
                4'd10:   c = CHAR_CR;
                4'd11:   c = CHAR_LF;
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    // Characters of the error notice.
    function automatic logic [7:0] err_char(input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (pos)
            3'd0:    c = "E";
            3'd1:    c = "R";
            3'd2:    c = "R";
            3'd3:    c = "O";
            3'd4:    c = "R";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- design/serial_module_link_bridge_top.sv -----
// Link bridge top level: sequencer, two bridging FIFOs in RAM and an output word queue.
//
//   Channel | Direction | Handshake         | Word
//   input   | in        | i_valid / o_ready | module and local bytes, ready flags
//   output  | out       | o_valid / i_ready | bytes to module and local, link phase
//
// One input word can be taken every cycle while o_ready is high. Its result word is formed
// from the registered read of the FIFO RAMs, with a bypass for a byte that is written and
// read in the same cycle, and is then written into the queue.
// Reset clears the sequencer, the FIFO pointers and the queue; the RAMs are not cleared.
// A four-word output queue absorbs stalls; o_ready falls once queue and pipe hold four words.
module serial_module_link_bridge_top #(
    parameter int FIFO_DEPTH = smlb_pkg::SMLB_FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_module_byte_valid,
    input  logic [7:0] i_module_byte,
    input  logic       i_local_byte_valid,
    input  logic [7:0] i_local_byte,
    input  logic       i_module_ready,
    input  logic       i_local_ready,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_to_module_valid,
    output logic [7:0] o_to_module_byte,
    output logic       o_to_local_valid,
    output logic [7:0] o_to_local_byte,
    output logic [3:0] o_link_phase
);
    import smlb_pkg::*;

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] FULL    = CW'(FIFO_DEPTH);
    localparam logic [AW:0]   DEPTH_X = (AW + 1)'(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(FIFO_DEPTH - 1);
    localparam int QD  = 4;
    localparam int QAW = 2;

    // Outcome of one tick on one FIFO.
    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic          pop_ok;
        logic [AW-1:0] raddr;
        logic          byp;
        logic [AW-1:0] head;
        logic [CW-1:0] count;
    } t_fifo_op;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    // Push first (overwriting the oldest word when full), then pop, then clear.
    function automatic t_fifo_op fifo_step(input logic [AW-1:0] head,
                                           input logic [CW-1:0] count,
                                           input logic push, input logic pop,
                                           input logic clr);
        t_fifo_op   op;
        logic [AW:0] sum;
        op       = '0;
        op.head  = head;
        op.count = count;
        sum      = {1'b0, head} + (AW + 1)'(count);
        if (push) begin
            op.we = 1'b1;
            if (count == FULL) begin
                op.waddr = head;
                op.head  = ptr_inc(head);
            end else begin
                op.waddr = (sum >= DEPTH_X) ? AW'(sum - DEPTH_X) : sum[AW-1:0];
                op.count = count + 1'b1;
            end
        end
        if (pop && (op.count != '0)) begin
            op.pop_ok = 1'b1;
            op.raddr  = op.head;
            op.byp    = op.we && (op.waddr == op.head);
            op.head   = ptr_inc(op.head);
            op.count  = op.count - 1'b1;
        end
        if (clr) begin
            op.head  = '0;
            op.count = '0;
        end
        return op;
    endfunction

    // Sequencer and FIFO pointer state
    t_phase        r_phase, n_phase, w_ph;
    logic [3:0]    r_cmd_pos, n_cmd_pos;
    logic          r_cmd_sel, n_cmd_sel;
    logic [1:0]    r_ntc_sel, n_ntc_sel;
    logic [3:0]    r_ntc_pos, n_ntc_pos;
    logic [2:0]    r_err_pos, n_err_pos;
    logic [AW-1:0] r_tl_head, r_tm_head;
    logic [CW-1:0] r_tl_count, r_tm_count;

    // FIFO RAMs and their registered read data
    logic [7:0]    r_tl_mem [FIFO_DEPTH];
    logic [7:0]    r_tm_mem [FIFO_DEPTH];
    logic [7:0]    r_tl_rdata, r_tm_rdata;

    // Pipe stage between the tick and the output queue
    logic          r_p_valid;
    logic          r_p_tm_valid, r_p_tm_reg, r_p_tl_valid, r_p_tl_reg;
    logic [7:0]    r_p_tm_byte, r_p_tl_byte;
    t_phase        r_p_phase;

    // Output queue
    t_result       r_q_mem [QD];
    logic [QAW-1:0] r_q_wr, r_q_rd;
    logic [QAW:0]  r_q_count;

    logic          w_accept, w_q_pop;
    logic          tl_push, tl_pop, tm_push, tm_pop, fifo_clr;
    logic          lit_tm_valid;
    logic [7:0]    lit_tm_byte;
    logic [3:0]    v_pos0;
    t_fifo_op      tl_op, tm_op;
    t_result       w_res, w_head;

    // Handshakes: room is counted over the queue and the word in the pipe.
    assign o_ready  = (r_q_count + (QAW + 1)'(r_p_valid)) < (QAW + 1)'(QD);
    assign w_accept = i_valid && o_ready;
    assign o_valid  = (r_q_count != '0);
    assign w_q_pop  = o_valid && i_ready;

    // Error matcher, sequencer and FIFO requests for one tick.
    always_comb begin
        n_phase      = r_phase;
        n_cmd_pos    = r_cmd_pos;
        n_cmd_sel    = r_cmd_sel;
        n_ntc_sel    = r_ntc_sel;
        n_ntc_pos    = r_ntc_pos;
        n_err_pos    = r_err_pos;
        tl_push      = 1'b0;
        tl_pop       = 1'b0;
        tm_push      = 1'b0;
        tm_pop       = 1'b0;
        fifo_clr     = 1'b0;
        lit_tm_valid = 1'b0;
        lit_tm_byte  = 8'h00;
        v_pos0       = r_ntc_pos;
        w_ph         = r_phase;

        // A completed error notice restarts the sequence on the following tick.
        if (r_err_pos >= ERR_LEN) begin
            n_err_pos = '0;
            w_ph      = PH_RST_START;
        end else if (i_module_byte_valid) begin
            if (i_module_byte == err_char(3'd0)) begin
                n_err_pos = 3'd1;
            end else if (i_module_byte == err_char(r_err_pos)) begin
                n_err_pos = r_err_pos + 3'd1;
            end else begin
                n_err_pos = '0;
            end
        end

        unique case (w_ph)
            PH_RST_START, PH_INQ_START: begin
                n_cmd_sel = (w_ph == PH_INQ_START) ? CMD_INQ : CMD_RESET;
                n_cmd_pos = '0;
                n_phase   = (w_ph == PH_INQ_START) ? PH_INQ_SEND : PH_RST_SEND;
            end
            PH_RST_SEND, PH_INQ_SEND: begin
                n_phase = w_ph;
                if (i_module_ready) begin
                    lit_tm_valid = 1'b1;
                    lit_tm_byte  = cmd_char(r_cmd_sel, r_cmd_pos);
                    n_cmd_pos    = r_cmd_pos + 4'd1;
                    if (!(n_cmd_pos < cmd_len(r_cmd_sel))) begin
                        n_phase = (w_ph == PH_RST_SEND) ? PH_READY_START : PH_SCAN_START;
                    end
                end
            end
            PH_READY_START, PH_SCAN_START, PH_CONN_START: begin
                n_ntc_pos = '0;
                if (w_ph == PH_READY_START) begin
                    n_ntc_sel = NTC_READY;
                    n_phase   = PH_READY_WAIT;
                end else if (w_ph == PH_SCAN_START) begin
                    n_ntc_sel = NTC_INQ;
                    n_phase   = PH_SCAN_WAIT;
                end else begin
                    n_ntc_sel = NTC_CONN;
                    n_phase   = PH_CONN_WAIT;
                end
            end
            PH_READY_WAIT, PH_SCAN_WAIT, PH_CONN_WAIT: begin
                n_phase = w_ph;
                if (!(r_ntc_pos < ntc_len(r_ntc_sel))) begin
                    if (w_ph == PH_READY_WAIT) begin
                        n_phase = PH_INQ_START;
                    end else if (w_ph == PH_SCAN_WAIT) begin
                        n_phase = PH_CONN_START;
                    end else begin
                        n_phase = PH_LINK_UP;
                    end
                end else if (i_module_byte_valid) begin
                    n_ntc_pos = (i_module_byte == ntc_char(r_ntc_sel, r_ntc_pos)) ?
                                r_ntc_pos + 4'd1 : 4'd0;
                end
            end
            PH_LINK_UP: begin
                n_phase = PH_CONNECTED;
            end
            PH_CONNECTED: begin
                n_phase = PH_CONNECTED;
                tl_push = i_module_byte_valid;
                tm_push = i_local_byte_valid;
                if (i_module_byte_valid && (i_module_byte == CHAR_CR)) begin
                    n_ntc_sel = NTC_READY;
                    n_ntc_pos = '0;
                    n_phase   = PH_VERIFY;
                end else begin
                    tl_pop = i_local_ready;
                    tm_pop = i_module_ready;
                end
            end
            PH_VERIFY: begin
                n_phase = PH_VERIFY;
                tm_push = i_local_byte_valid;
                if (!(r_ntc_pos < ntc_len(r_ntc_sel))) begin
                    n_phase  = PH_RST_START;
                    fifo_clr = 1'b1;
                end else if (i_module_byte_valid) begin
                    tl_push = 1'b1;
                    v_pos0  = (i_module_byte == CHAR_CR) ? 4'd0 : r_ntc_pos;
                    if ((v_pos0 < ntc_len(r_ntc_sel)) &&
                        (i_module_byte == ntc_char(r_ntc_sel, v_pos0))) begin
                        n_ntc_pos = v_pos0 + 4'd1;
                    end else begin
                        n_ntc_pos = v_pos0;
                        n_phase   = PH_CONNECTED;
                    end
                end
            end
            default: begin
                n_phase = w_ph;
            end
        endcase

        tl_op = fifo_step(r_tl_head, r_tl_count, tl_push, tl_pop, fifo_clr);
        tm_op = fifo_step(r_tm_head, r_tm_count, tm_push, tm_pop, fifo_clr);
    end

    // Sequencer and pointer registers advance on each accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_RST_START;
            r_cmd_pos  <= '0;
            r_cmd_sel  <= CMD_RESET;
            r_ntc_sel  <= NTC_READY;
            r_ntc_pos  <= '0;
            r_err_pos  <= '0;
            r_tl_head  <= '0;
            r_tl_count <= '0;
            r_tm_head  <= '0;
            r_tm_count <= '0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_cmd_pos  <= n_cmd_pos;
            r_cmd_sel  <= n_cmd_sel;
            r_ntc_sel  <= n_ntc_sel;
            r_ntc_pos  <= n_ntc_pos;
            r_err_pos  <= n_err_pos;
            r_tl_head  <= tl_op.head;
            r_tl_count <= tl_op.count;
            r_tm_head  <= tm_op.head;
            r_tm_count <= tm_op.count;
        end
    end

    // FIFO RAMs: one write and one registered read per tick, old data on a clash.
    always_ff @(posedge i_clk) begin
        if (w_accept && tl_op.we) begin
            r_tl_mem[tl_op.waddr] <= i_module_byte;
        end
        if (w_accept) begin
            r_tl_rdata <= r_tl_mem[tl_op.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && tm_op.we) begin
            r_tm_mem[tm_op.waddr] <= i_local_byte;
        end
        if (w_accept) begin
            r_tm_rdata <= r_tm_mem[tm_op.raddr];
        end
    end

    // Pipe stage: a register byte stands in for RAM data (command bytes and bypass).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_tm_valid <= lit_tm_valid | tm_op.pop_ok;
            r_p_tm_reg   <= lit_tm_valid | tm_op.byp;
            r_p_tm_byte  <= lit_tm_valid ? lit_tm_byte : i_local_byte;
            r_p_tl_valid <= tl_op.pop_ok;
            r_p_tl_reg   <= tl_op.byp;
            r_p_tl_byte  <= i_module_byte;
            r_p_phase    <= n_phase;
        end
    end

    // Result word: bytes read as zero when nothing is sent.
    always_comb begin
        w_res.tm_valid = r_p_tm_valid;
        w_res.tm_byte  = !r_p_tm_valid ? 8'h00 : (r_p_tm_reg ? r_p_tm_byte : r_tm_rdata);
        w_res.tl_valid = r_p_tl_valid;
        w_res.tl_byte  = !r_p_tl_valid ? 8'h00 : (r_p_tl_reg ? r_p_tl_byte : r_tl_rdata);
        w_res.phase    = r_p_phase;
    end

    // Output queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr    <= '0;
            r_q_rd    <= '0;
            r_q_count <= '0;
        end else begin
            if (r_p_valid) begin
                r_q_wr <= r_q_wr + 1'b1;
            end
            if (w_q_pop) begin
                r_q_rd <= r_q_rd + 1'b1;
            end
            r_q_count <= r_q_count + (QAW + 1)'(r_p_valid) - (QAW + 1)'(w_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_valid) begin
            r_q_mem[r_q_wr] <= w_res;
        end
    end

    // Output ports from the queue head
    assign w_head            = r_q_mem[r_q_rd];
    assign o_to_module_valid = w_head.tm_valid;
    assign o_to_module_byte  = w_head.tm_byte;
    assign o_to_local_valid  = w_head.tl_valid;
    assign o_to_local_byte   = w_head.tl_byte;
    assign o_link_phase      = w_head.phase;

    // Checks on the queue credit, the bridging path and the disconnect flush.
`include "serial_module_link_bridge_top_assert.svh"
    `SMLB_ASSERT_HOLDS(a_queue_credit, i_clk, i_rst_n,
        ((r_q_count + (QAW + 1)'(r_p_valid)) <= (QAW + 1)'(QD)),
        "output queue and pipe hold more words than the queue can take")
    `SMLB_ASSERT_IMPL(a_local_only_connected, i_clk, i_rst_n,
        (r_p_valid && r_p_tl_valid), (r_p_phase == PH_CONNECTED),
        "byte to the local device outside the connected phase")
    `SMLB_ASSERT_NEXT(a_verify_flush, i_clk, i_rst_n,
        (w_accept && (r_phase == PH_VERIFY) && (n_phase == PH_RST_START)),
        ((r_tl_count == '0) && (r_tm_count == '0)),
        "FIFOs not empty after a disconnect notice")
    `SMLB_ASSERT_IMPL(a_bypass_on_empty, i_clk, i_rst_n,
        (w_accept && tl_op.byp), (r_tl_count == '0),
        "read bypass taken while the local FIFO held data")

endmodule
